@@ hdl/scba_pkg.sv @@
`timescale 1ns / 1ps

package scba_pkg;

    localparam int ADDR_W          = 24;
    localparam int SIZE_W          = 16;
    localparam int CLASS_W         = 4;
    localparam int STATUS_W        = 2;
    localparam int BASE_W          = 40;
    localparam int MIN_BLOCK_SHIFT = 4;
    localparam int MIN_BLOCK_BYTES = 16;

    localparam int DEF_NUM_CLASSES        = 12;
    localparam int DEF_WORD_BITS          = 16;
    localparam int DEF_BLOCKS_PER_SEGMENT = 64;
    localparam int DEF_SEGMENTS_PER_CLASS = 4;

    localparam logic KIND_FREE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } scba_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   result_address;
        logic [CLASS_W-1:0]  size_class;
    } scba_rsp_t;

    typedef struct packed {
        logic               too_large;
        logic [CLASS_W-1:0] alloc_class;
        logic               outside;
        logic [CLASS_W-1:0] free_class;
        logic [ADDR_W-1:0]  free_offset;
    } scba_dec_t;

    // region base of class cls: region0 * (2^cls - 1)
    function automatic logic [BASE_W-1:0] class_base(input logic [BASE_W-1:0] region0,
                                                    input logic [CLASS_W:0]   cls);
        return (region0 << cls) - region0;
    endfunction

endpackage

@@ hdl/scba_ram.sv @@
`timescale 1ns / 1ps

module scba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 192
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/scba_decode.sv @@
`timescale 1ns / 1ps

module scba_decode import scba_pkg::*; #(
    parameter int NUM_CLASSES        = DEF_NUM_CLASSES,
    parameter int BLOCKS_PER_SEGMENT = DEF_BLOCKS_PER_SEGMENT,
    parameter int SEGMENTS_PER_CLASS = DEF_SEGMENTS_PER_CLASS
) (
    input  scba_req_t req,
    output scba_dec_t dec
);

    localparam int UNITS_W = SIZE_W - MIN_BLOCK_SHIFT;
    localparam logic [BASE_W-1:0] REGION0 =
        BASE_W'(SEGMENTS_PER_CLASS * BLOCKS_PER_SEGMENT * MIN_BLOCK_BYTES);
    localparam logic [SIZE_W+3:0] MAX_SIZE =
        (SIZE_W + 4)'(MIN_BLOCK_BYTES) << (NUM_CLASSES - 1);

    logic [SIZE_W-1:0]  size_m1;
    logic [UNITS_W-1:0] units;
    logic [CLASS_W-1:0] acls;
    logic [CLASS_W-1:0] fcls;
    logic [NUM_CLASSES:0] ge;
    logic [BASE_W-1:0]  base_full;
    logic [ADDR_W-1:0]  base_sel;

    // allocate: class = bit length of (size-1)/16
    always_comb
    begin
        size_m1 = req.request_size - SIZE_W'(1);
        units   = size_m1[SIZE_W-1:MIN_BLOCK_SHIFT];
        acls    = '0;
        if (req.request_size > SIZE_W'(MIN_BLOCK_BYTES))
        begin
            for (int i = 0; i < UNITS_W; i++)
            begin
                if (units[i])
                begin
                    acls = CLASS_W'(i + 1);
                end
            end
        end
    end

    // free: compare against every region boundary, take the highest one passed
    always_comb
    begin
        fcls      = '0;
        base_sel  = '0;
        base_full = '0;
        for (int c = 0; c <= NUM_CLASSES; c++)
        begin
            ge[c] = {(BASE_W - ADDR_W)'(0), req.block_address} >=
                    class_base(REGION0, (CLASS_W + 1)'(c));
        end
        for (int c = 1; c < NUM_CLASSES; c++)
        begin
            if (ge[c])
            begin
                fcls      = CLASS_W'(c);
                base_full = class_base(REGION0, (CLASS_W + 1)'(c));
                base_sel  = base_full[ADDR_W-1:0];
            end
        end
    end

    assign dec.too_large   = {4'b0, req.request_size} > MAX_SIZE;
    assign dec.alloc_class = acls;
    assign dec.outside     = ge[NUM_CLASSES];
    assign dec.free_class  = fcls;
    assign dec.free_offset = req.block_address - base_sel;

endmodule

@@ hdl/scba_seq.sv @@
`timescale 1ns / 1ps

module scba_seq import scba_pkg::*; #(
    parameter int NUM_CLASSES        = DEF_NUM_CLASSES,
    parameter int WORD_BITS          = DEF_WORD_BITS,
    parameter int BLOCKS_PER_SEGMENT = DEF_BLOCKS_PER_SEGMENT,
    parameter int SEGMENTS_PER_CLASS = DEF_SEGMENTS_PER_CLASS,
    localparam int WPS   = (BLOCKS_PER_SEGMENT + WORD_BITS - 1) / WORD_BITS,
    localparam int TOTAL = NUM_CLASSES * SEGMENTS_PER_CLASS * WPS,
    localparam int AW    = TOTAL > 1 ? $clog2(TOTAL) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 kind,
    input  scba_dec_t            dec,
    output logic                 busy,
    output logic                 done,
    output scba_rsp_t            result,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output logic [WORD_BITS-1:0] mem_wdata,
    output logic                 mem_re,
    output logic [AW-1:0]        mem_raddr,
    input  logic [WORD_BITS-1:0] mem_rdata
);

    localparam int WPC    = SEGMENTS_PER_CLASS * WPS;
    localparam int SEG_W  = SEGMENTS_PER_CLASS > 1 ? $clog2(SEGMENTS_PER_CLASS) : 1;
    localparam int WPS_W  = WPS > 1 ? $clog2(WPS) : 1;
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int N_W    = $clog2(SEGMENTS_PER_CLASS * BLOCKS_PER_SEGMENT);
    localparam int DV_W   = (N_W > BIT_W ? N_W : BIT_W) + 1;
    localparam int LAST_BITS = BLOCKS_PER_SEGMENT - (WPS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
    localparam logic [BASE_W-1:0] REGION0 =
        BASE_W'(SEGMENTS_PER_CLASS * BLOCKS_PER_SEGMENT * MIN_BLOCK_BYTES);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_FRD   = 3'd6;
    localparam logic [2:0] S_FWR   = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               done_reg, done_next;
    scba_rsp_t          result_reg, result_next;
    logic [CLASS_W-1:0] cls_reg, cls_next;
    logic [SEG_W-1:0]   seg_reg, seg_next;
    logic [WPS_W-1:0]   w_reg, w_next;
    logic [BIT_W-1:0]   b_reg, b_next;
    logic [ADDR_W-1:0]  off_reg, off_next;
    logic [DV_W-1:0]    rem_reg, rem_next;
    logic               phase_reg, phase_next;

    logic [WORD_BITS-1:0] vmask;
    logic [WORD_BITS-1:0] masked;
    logic                 hit;
    logic [BIT_W-1:0]     hit_bit;
    logic                 last_word;
    logic [AW-1:0]        class_idx;
    logic [AW-1:0]        free_idx;
    logic [BASE_W-1:0]    base_full;
    logic [ADDR_W-1:0]    n_blk;
    logic [ADDR_W-1:0]    addr_calc;
    logic [SEG_W-1:0]     seg_q;
    logic [DV_W-1:0]      seg_base;
    logic [WPS_W-1:0]     w_q;
    logic [DV_W-1:0]      w_base;

    // lowest free block in the word just read; spare bits of a segment's last word masked off
    always_comb
    begin
        vmask   = (w_reg == WPS_W'(WPS - 1)) ? LAST_MASK : '1;
        masked  = mem_rdata & vmask;
        hit     = |masked;
        hit_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                hit_bit = BIT_W'(i);
            end
        end
    end

    assign last_word = (seg_reg == SEG_W'(SEGMENTS_PER_CLASS - 1)) &&
                       (w_reg == WPS_W'(WPS - 1));
    assign class_idx = AW'(dec.alloc_class) * AW'(WPC);
    assign free_idx  = AW'(cls_reg) * AW'(WPC) + AW'(seg_reg) * AW'(WPS) + AW'(w_reg);

    always_comb
    begin
        base_full = class_base(REGION0, {1'b0, cls_reg});
        n_blk     = ADDR_W'(seg_reg) * ADDR_W'(BLOCKS_PER_SEGMENT) +
                    ADDR_W'(w_reg) * ADDR_W'(WORD_BITS) + ADDR_W'(b_reg);
        addr_calc = base_full[ADDR_W-1:0] + (n_blk << (MIN_BLOCK_SHIFT + cls_reg));
    end

    // quotient by comparing against constant multiples of the divisor
    always_comb
    begin
        seg_q    = '0;
        seg_base = '0;
        for (int s = 1; s < SEGMENTS_PER_CLASS; s++)
        begin
            if (rem_reg >= DV_W'(s * BLOCKS_PER_SEGMENT))
            begin
                seg_q    = SEG_W'(s);
                seg_base = DV_W'(s * BLOCKS_PER_SEGMENT);
            end
        end
        w_q    = '0;
        w_base = '0;
        for (int i = 1; i < WPS; i++)
        begin
            if (rem_reg >= DV_W'(i * WORD_BITS))
            begin
                w_q    = WPS_W'(i);
                w_base = DV_W'(i * WORD_BITS);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        cls_next    = cls_reg;
        seg_next    = seg_reg;
        w_next      = w_reg;
        b_next      = b_reg;
        off_next    = off_reg;
        rem_next    = rem_reg;
        phase_next  = phase_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = '1;
        mem_re      = 1'b0;
        mem_raddr   = idx_reg;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (idx_reg == AW'(TOTAL - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_FREE)
                    begin
                        if (dec.outside)
                        begin
                            result_next.status         = ST_OUTSIDE;
                            result_next.result_address = '0;
                            result_next.size_class     = '0;
                            done_next                  = 1'b1;
                        end
                        else
                        begin
                            cls_next   = dec.free_class;
                            off_next   = dec.free_offset;
                            state_next = S_SHIFT;
                        end
                    end
                    else if (dec.too_large)
                    begin
                        result_next.status         = ST_TOO_LARGE;
                        result_next.result_address = '0;
                        result_next.size_class     = '0;
                        done_next                  = 1'b1;
                    end
                    else
                    begin
                        cls_next   = dec.alloc_class;
                        idx_next   = class_idx;
                        seg_next   = '0;
                        w_next     = '0;
                        mem_re     = 1'b1;
                        mem_raddr  = class_idx;
                        state_next = S_SCAN;
                    end
                end
            end

            // one bitmap word per cycle; next read issued while this one is checked
            S_SCAN:
            begin
                if (hit)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = mem_rdata & ~(WORD_BITS'(1) << hit_bit);
                    b_next     = hit_bit;
                    state_next = S_ADDR;
                end
                else if (last_word)
                begin
                    result_next.status         = ST_EXHAUSTED;
                    result_next.result_address = '0;
                    result_next.size_class     = cls_reg;
                    done_next                  = 1'b1;
                    state_next                 = S_IDLE;
                end
                else
                begin
                    idx_next  = idx_reg + AW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + AW'(1);
                    if (w_reg == WPS_W'(WPS - 1))
                    begin
                        w_next   = '0;
                        seg_next = seg_reg + SEG_W'(1);
                    end
                    else
                    begin
                        w_next = w_reg + WPS_W'(1);
                    end
                end
            end

            S_ADDR:
            begin
                result_next.status         = ST_OK;
                result_next.result_address = addr_calc;
                result_next.size_class     = cls_reg;
                done_next                  = 1'b1;
                state_next                 = S_IDLE;
            end

            S_SHIFT:
            begin
                rem_next   = DV_W'(off_reg >> (MIN_BLOCK_SHIFT + cls_reg));
                phase_next = 1'b0;
                state_next = S_DIV;
            end

            // block index -> segment, then word and bit
            S_DIV:
            begin
                if (!phase_reg)
                begin
                    seg_next   = seg_q;
                    rem_next   = rem_reg - seg_base;
                    phase_next = 1'b1;
                end
                else
                begin
                    w_next     = w_q;
                    b_next     = BIT_W'(rem_reg - w_base);
                    state_next = S_FRD;
                end
            end

            S_FRD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = free_idx;
                idx_next   = free_idx;
                state_next = S_FWR;
            end

            S_FWR:
            begin
                mem_we                     = 1'b1;
                mem_wdata                  = mem_rdata | (WORD_BITS'(1) << b_reg);
                result_next.status         = ST_OK;
                result_next.result_address = '0;
                result_next.size_class     = cls_reg;
                done_next                  = 1'b1;
                state_next                 = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        cls_reg    <= cls_next;
        seg_reg    <= seg_next;
        w_reg      <= w_next;
        b_reg      <= b_next;
        off_reg    <= off_next;
        rem_reg    <= rem_next;
        phase_reg  <= phase_next;
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe outside idle");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !mem_we)
        else $error("bitmap write while idle");

    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == S_IDLE) |=> (state_reg != S_IDLE || done_reg))
        else $error("accepted request neither started nor answered");

    a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.status != ST_OK) |-> result_reg.result_address == '0)
        else $error("error result with nonzero address");

endmodule

@@ hdl/size_class_bitmap_allocator.sv @@
// channel   | ports                 | transfer
// ----------+-----------------------+------------------------------------------
// request   | start, busy, request  | edge with start high and busy low
// result    | done, result          | edge ending the single cycle done is high
//
// Allocate: the class's bitmap words are read in order (one RAM read per cycle, up to
//   SEGMENTS_PER_CLASS * words per segment, 16 by default); a hit clears its bit and
//   S_ADDR forms the address, else exhausted; too large or outside: answered in idle.
// Free: shift, two compare-and-subtract steps, RAM read, write back.
// After reset the bitmap RAM is filled with ones, one word per cycle (192 by
//   default) with busy high. The receiver cannot stall; done is a one-cycle strobe.
`timescale 1ns / 1ps

module size_class_bitmap_allocator import scba_pkg::*; #(
    parameter int NUM_CLASSES        = DEF_NUM_CLASSES,
    parameter int WORD_BITS          = DEF_WORD_BITS,
    parameter int BLOCKS_PER_SEGMENT = DEF_BLOCKS_PER_SEGMENT,
    parameter int SEGMENTS_PER_CLASS = DEF_SEGMENTS_PER_CLASS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  scba_req_t request,
    output logic      done,
    output scba_rsp_t result
);

    localparam int WPS   = (BLOCKS_PER_SEGMENT + WORD_BITS - 1) / WORD_BITS;
    localparam int TOTAL = NUM_CLASSES * SEGMENTS_PER_CLASS * WPS;
    localparam int AW    = TOTAL > 1 ? $clog2(TOTAL) : 1;

    scba_dec_t            dec;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    scba_decode #(
        .NUM_CLASSES        (NUM_CLASSES),
        .BLOCKS_PER_SEGMENT (BLOCKS_PER_SEGMENT),
        .SEGMENTS_PER_CLASS (SEGMENTS_PER_CLASS)
    ) u_decode (
        .req (request),
        .dec (dec)
    );

    scba_seq #(
        .NUM_CLASSES        (NUM_CLASSES),
        .WORD_BITS          (WORD_BITS),
        .BLOCKS_PER_SEGMENT (BLOCKS_PER_SEGMENT),
        .SEGMENTS_PER_CLASS (SEGMENTS_PER_CLASS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (request.kind),
        .dec       (dec),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    scba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TOTAL)
    ) u_bitmap (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
